// File: sv/rsp_pkg.sv
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity block.
package rsp_pkg;

    localparam int MAX_DEGREE_DEF = 20;
    localparam int RESET_DEGREE   = 7;
    localparam int CFG_W          = 5;
    localparam int DEG_W          = 6;
    localparam int ADDR_W         = 3;
    localparam int DATA_W         = 32;
    localparam int QUEUE_DEPTH    = 2;

    // Low byte of the field polynomial 0x11D; bit 8 falls out of the shift
    localparam logic [7:0] FIELD_POLY  = 8'h1D;
    localparam logic [7:0] FIELD_ALPHA = 8'h02;

    localparam logic REG_ECC_DEGREE = 1'b0;

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_INIT,
        GEN_BUILD
    } gen_state_t;

    typedef struct packed {
        logic             busy;
        logic             clear;
        logic [DEG_W-1:0] degree;
    } gen_ctl_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int i = 7; i >= 0; i--)
        begin
            acc = {acc[6:0], 1'b0} ^ (acc[7] ? FIELD_POLY : 8'h00);
            if (b[i])
            begin
                acc = acc ^ a;
            end
        end
        return acc;
    endfunction

    function automatic logic [DEG_W-1:0] clamp_degree(input logic [CFG_W-1:0] raw,
                                                      input logic [DEG_W-1:0] max_deg);
        logic [DEG_W-1:0] wide;
        wide = DEG_W'(raw);
        if (wide == '0)
        begin
            return DEG_W'(1);
        end
        if (wide > max_deg)
        begin
            return max_deg;
        end
        return wide;
    endfunction

endpackage

// File: sv/rsp_gen.sv
// Configuration register and sequential generator-polynomial builder.
module rsp_gen #(
    parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rsp_pkg::ADDR_W-1:0]        paddr,
    input  logic [rsp_pkg::DATA_W-1:0]        pwdata,
    output logic [rsp_pkg::DATA_W-1:0]        prdata,
    output logic                              pready,
    output rsp_pkg::gen_ctl_t                 ctl,
    output logic [MAX_DEGREE-1:0][7:0]        gen_coeffs
);

    localparam int DW = rsp_pkg::DEG_W;
    localparam logic [DW-1:0] MAX_D = DW'(MAX_DEGREE);

    rsp_pkg::gen_state_t state_reg, state_next;
    logic [rsp_pkg::CFG_W-1:0]   ecc_reg;
    logic [DW-1:0]               deg_reg;
    logic [DW-1:0]               step_reg, step_next;
    logic [7:0]                  root_reg, root_next;
    logic [MAX_DEGREE-1:0][7:0]  g_reg, g_next, g_up;
    logic                        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == rsp_pkg::REG_ECC_DEGREE);
    assign prdata = (paddr[2] == rsp_pkg::REG_ECC_DEGREE) ? rsp_pkg::DATA_W'(ecc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ecc_reg <= rsp_pkg::CFG_W'(rsp_pkg::RESET_DEGREE);
            deg_reg <= rsp_pkg::clamp_degree(rsp_pkg::CFG_W'(rsp_pkg::RESET_DEGREE), MAX_D);
        end
        else if (wr_en)
        begin
            ecc_reg <= pwdata[rsp_pkg::CFG_W-1:0];
            deg_reg <= rsp_pkg::clamp_degree(pwdata[rsp_pkg::CFG_W-1:0], MAX_D);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsp_pkg::GEN_IDLE:
            begin
                if (wr_en)
                begin
                    state_next = rsp_pkg::GEN_INIT;
                end
            end
            rsp_pkg::GEN_INIT:
            begin
                state_next = wr_en ? rsp_pkg::GEN_INIT : rsp_pkg::GEN_BUILD;
            end
            rsp_pkg::GEN_BUILD:
            begin
                if (wr_en)
                begin
                    state_next = rsp_pkg::GEN_INIT;
                end
                else if (step_reg == deg_reg - DW'(1))
                begin
                    state_next = rsp_pkg::GEN_IDLE;
                end
            end
            default:
            begin
                state_next = rsp_pkg::GEN_INIT;
            end
        endcase
    end

    // Entries at or above the degree stay zero, so the shifted-in term needs no guard
    assign g_up = g_reg >> 8;

    // Datapath outputs of the builder
    always_comb
    begin
        g_next    = g_reg;
        root_next = root_reg;
        step_next = step_reg;
        unique case (state_reg)
            rsp_pkg::GEN_IDLE:
            begin
                g_next = g_reg;
            end
            rsp_pkg::GEN_INIT:
            begin
                // Start from the monic x^0 term placed at the top coefficient
                for (int j = 0; j < MAX_DEGREE; j++)
                begin
                    g_next[j] = (DW'(j) == deg_reg - DW'(1)) ? 8'h01 : 8'h00;
                end
                root_next = 8'h01;
                step_next = '0;
            end
            rsp_pkg::GEN_BUILD:
            begin
                // Multiply by (x - root) across all coefficients at once
                for (int j = 0; j < MAX_DEGREE; j++)
                begin
                    g_next[j] = rsp_pkg::gf_mul(g_reg[j], root_reg) ^ g_up[j];
                end
                root_next = rsp_pkg::gf_mul(root_reg, rsp_pkg::FIELD_ALPHA);
                step_next = step_reg + DW'(1);
            end
            default:
            begin
                g_next = g_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsp_pkg::GEN_INIT;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg    <= g_next;
        root_reg <= root_next;
    end

    assign gen_coeffs = g_reg;
    assign ctl.busy   = (state_reg != rsp_pkg::GEN_IDLE);
    assign ctl.clear  = wr_en;
    assign ctl.degree = deg_reg;

    a_deg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (deg_reg != '0) && (deg_reg <= MAX_D))
        else $error("effective degree out of range");

endmodule

// File: sv/rsp_front.sv
// Front end: takes message words and folds them into the LFSR remainder.
module rsp_front #(
    parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsp_pkg::gen_ctl_t                 ctl,
    input  logic [MAX_DEGREE-1:0][7:0]        gen_coeffs,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,
    input  logic                              s_tlast,
    input  logic                              q_full,
    output logic                              push,
    output logic [MAX_DEGREE-1:0][7:0]        push_data
);

    logic [MAX_DEGREE-1:0][7:0] rem_reg, rem_next, rem_up, rem_upd;
    logic [7:0]                 factor;
    logic                       accept;

    assign s_tready = !ctl.busy && !q_full;
    assign accept   = s_tvalid && s_tready;
    assign factor   = s_tdata ^ rem_reg[0];
    assign rem_up   = rem_reg >> 8;

    always_comb
    begin
        for (int j = 0; j < MAX_DEGREE; j++)
        begin
            rem_upd[j] = rem_up[j] ^ rsp_pkg::gf_mul(gen_coeffs[j], factor);
        end
    end

    always_comb
    begin
        rem_next = rem_reg;
        if (ctl.clear)
        begin
            rem_next = '0;
        end
        else if (accept)
        begin
            // Drop the remainder once a message is complete
            rem_next = s_tlast ? '0 : rem_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else
        begin
            rem_reg <= rem_next;
        end
    end

    assign push      = accept && s_tlast;
    assign push_data = rem_upd;

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |=> (rem_reg == '0))
        else $error("remainder not cleared after degree write");

endmodule

// File: sv/rsp_queue.sv
// Two-entry queue of finished remainders between front and back end.
module rsp_queue #(
    parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic [MAX_DEGREE-1:0][7:0]        push_data,
    output logic                              full,
    input  logic                              pop,
    output logic [MAX_DEGREE-1:0][7:0]        pop_data,
    output logic                              empty
);

    localparam int DEPTH = rsp_pkg::QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [MAX_DEGREE-1:0][7:0] mem_reg [DEPTH];
    logic [PW-1:0]              wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]                count_reg, count_next;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + (PW+1)'(1);
            2'b01:   count_next = count_reg - (PW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from empty queue");

endmodule

// File: sv/rsp_back.sv
// Back end: serialises a finished remainder into parity words, highest order first.
module rsp_back #(
    parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  rsp_pkg::gen_ctl_t                 ctl,
    input  logic                              empty,
    input  logic [MAX_DEGREE-1:0][7:0]        pop_data,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,
    output logic                              m_tlast
);

    localparam int DW = rsp_pkg::DEG_W;

    logic [MAX_DEGREE-1:0][7:0] sh_reg;
    logic [DW-1:0]              cnt_reg;
    logic                       valid_reg;
    logic                       fire, final_word;

    assign fire       = valid_reg && m_tready;
    assign final_word = (cnt_reg == DW'(1));
    // Reload behind the final word so messages leave back to back
    assign pop        = !empty && (!valid_reg || (fire && final_word));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
            cnt_reg   <= ctl.degree;
        end
        else if (fire)
        begin
            valid_reg <= !final_word;
            cnt_reg   <= cnt_reg - DW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sh_reg <= pop_data;
        end
        else if (fire)
        begin
            sh_reg <= sh_reg >> 8;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = sh_reg[0];
    assign m_tlast  = final_word;

    a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((cnt_reg != '0) && (cnt_reg <= ctl.degree)))
        else $error("parity count out of range while presenting a word");

endmodule

// File: sv/reed_solomon_parity_gf256_top.sv
// Top level of the GF(256) Reed-Solomon parity generator.
//
// Message bytes enter on the slave stream (s_tdata, s_tlast marks the final
// byte). Each accepted byte is folded into the registered LFSR remainder,
// so the input sustains one byte per clock while s_tready is high. Data
// bytes are not echoed. After the final byte the remainder moves into a
// two-entry queue and the back end emits ecc_degree parity words on the
// master stream, highest order first, with m_tlast on the last one; the
// remainder passes the queue and the back end's shift register before its
// first parity word is valid. A message occupies the output for ecc_degree
// words, so apart from a generator build the input stalls only when two
// finished remainders are already waiting, e.g. for messages shorter than
// the degree. A receiver stall holds the current parity word and backs up
// into the queue, then the input. Register ecc_degree (APB, address 0)
// sets the parity length; 0 counts as 1 and values above MAX_DEGREE as
// MAX_DEGREE. Writing it clears the remainder and rebuilds the generator
// with s_tready low. After reset the same build runs for degree 7.
module reed_solomon_parity_gf256_top #(
    parameter int MAX_DEGREE = rsp_pkg::MAX_DEGREE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [rsp_pkg::DATA_W-1:0]    pwdata,
    output logic [rsp_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] parity_byte
    output logic                          m_tlast
);

    rsp_pkg::gen_ctl_t          ctl;
    logic [MAX_DEGREE-1:0][7:0] gen_coeffs;
    logic [MAX_DEGREE-1:0][7:0] push_data, pop_data;
    logic                       push, pop, full, empty;

    rsp_gen #(.MAX_DEGREE(MAX_DEGREE)) u_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .ctl        (ctl),
        .gen_coeffs (gen_coeffs)
    );

    rsp_front #(.MAX_DEGREE(MAX_DEGREE)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .gen_coeffs (gen_coeffs),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (full),
        .push       (push),
        .push_data  (push_data)
    );

    rsp_queue #(.MAX_DEGREE(MAX_DEGREE)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    rsp_back #(.MAX_DEGREE(MAX_DEGREE)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sim/reed_solomon_parity_gf256_top_tb.sv
// Self-checking testbench for the GF(256) Reed-Solomon parity generator top level.
`timescale 1ns / 1ps

module reed_solomon_parity_gf256_top_tb;

    localparam int MAX_DEG      = rsp_pkg::MAX_DEGREE_DEF;
    localparam int SETTLE       = 4;
    localparam int TAIL_CYCLES  = 30;
    localparam int HOLD_CYCLES  = 250;
    localparam int STALL_LIMIT  = 4000;
    localparam int RUN_LIMIT    = 100000;
    localparam int SHOWN_ERRORS = 10;

    localparam logic [rsp_pkg::ADDR_W-1:0] DEGREE_ADDR =
        rsp_pkg::ADDR_W'(4 * rsp_pkg::REG_ECC_DEGREE);
    localparam logic [rsp_pkg::ADDR_W-1:0] SPARE_ADDR  = rsp_pkg::ADDR_W'(4);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    typedef struct packed {
        logic [7:0] parity;
        logic       tail;
    } parity_word_t;

    logic                         clk      = 1'b0;
    logic                         rst_n    = 1'b0;
    logic                         psel     = 1'b0;
    logic                         penable  = 1'b0;
    logic                         pwrite   = 1'b0;
    logic [rsp_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [rsp_pkg::DATA_W-1:0]   pwdata   = '0;
    logic [rsp_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata  = '0;   // [7:0] data_byte
    logic                         s_tlast  = 1'b0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [7:0]                   m_tdata;         // [7:0] parity_byte
    logic                         m_tlast;

    // predictor state
    logic [7:0]                   gen_coef [MAX_DEG];
    logic [7:0]                   lfsr_rem [MAX_DEG];
    int                           deg_eff;
    logic [rsp_pkg::CFG_W-1:0]    deg_raw;

    msg_byte_t                    byte_backlog [$];
    msg_byte_t                    byte_next;
    parity_word_t                 parity_due [$];
    parity_word_t                 parity_head;
    logic                         byte_taken;

    int                           send_idle_pct = 0;
    int                           recv_stall_pct = 0;
    logic                         hold_req = 1'b0;
    int                           hold_count = 0;
    int                           stall_cnt;
    int                           run_cycles;
    int                           mismatch_cnt = 0;
    int                           bytes_in = 0;
    int                           msgs_in = 0;
    int                           words_out = 0;
    int                           degree_writes = 0;
    logic [rsp_pkg::DATA_W-1:0]   readback;

    reed_solomon_parity_gf256_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 clk = ~clk;

    // shift-and-add multiply, reducing by the field polynomial as x grows
    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = 8'h00;
        x = a;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                p = p ^ x;
            end
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1D : 8'h00);
        end
        return p;
    endfunction

    function automatic void load_degree(input logic [rsp_pkg::CFG_W-1:0] raw);
        logic [7:0] root;
        int         d;
        deg_raw = raw;
        d = (raw == 0) ? 1 : ((int'(raw) > MAX_DEG) ? MAX_DEG : int'(raw));
        deg_eff = d;
        for (int j = 0; j < MAX_DEG; j++)
        begin
            gen_coef[j] = 8'h00;
            lfsr_rem[j] = 8'h00;
        end
        gen_coef[d - 1] = 8'h01;
        root = 8'h01;
        // multiply in (x - 2^i) one root at a time
        for (int i = 0; i < d; i++)
        begin
            for (int j = 0; j < d; j++)
            begin
                gen_coef[j] = gf_product(gen_coef[j], root);
                if (j + 1 < d)
                begin
                    gen_coef[j] = gen_coef[j] ^ gen_coef[j + 1];
                end
            end
            root = gf_product(root, 8'h02);
        end
    endfunction

    function automatic void absorb_byte(input logic [7:0] data, input logic last);
        logic [7:0] factor;
        factor = data ^ lfsr_rem[0];
        for (int j = 0; j + 1 < deg_eff; j++)
        begin
            lfsr_rem[j] = lfsr_rem[j + 1];
        end
        lfsr_rem[deg_eff - 1] = 8'h00;
        for (int j = 0; j < deg_eff; j++)
        begin
            lfsr_rem[j] = lfsr_rem[j] ^ gf_product(gen_coef[j], factor);
        end
        if (last)
        begin
            for (int j = 0; j < deg_eff; j++)
            begin
                parity_due.push_back('{parity: lfsr_rem[j], tail: (j + 1 == deg_eff)});
                lfsr_rem[j] = 8'h00;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_cnt++;
        if (mismatch_cnt <= SHOWN_ERRORS)
        begin
            $display("MISMATCH %s: expected %0h, got %0h", what, want, got);
        end
    endtask

    // sender: offer the next backlog word once the current one has gone
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_taken <= 1'b0;
        end
        else
        begin
            byte_taken <= s_tvalid && s_tready;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || byte_taken)
        begin
            if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                byte_next = byte_backlog.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= byte_next.data;
                s_tlast  <= byte_next.last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off when requested
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_req && hold_count < HOLD_CYCLES)
        begin
            hold_count++;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: check parity words, then fold in any accepted message byte
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                words_out++;
                if (parity_due.size() == 0)
                begin
                    report_mismatch("parity word with nothing outstanding", 32'h0,
                                    {23'h0, m_tlast, m_tdata});
                end
                else
                begin
                    parity_head = parity_due.pop_front();
                    if (m_tdata !== parity_head.parity)
                    begin
                        report_mismatch("parity_byte", 32'(parity_head.parity), 32'(m_tdata));
                    end
                    if (m_tlast !== parity_head.tail)
                    begin
                        report_mismatch("last_parity", 32'(parity_head.tail), 32'(m_tlast));
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                bytes_in++;
                if (s_tlast)
                begin
                    msgs_in++;
                end
                absorb_byte(s_tdata, s_tlast);
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cnt <= 0;
        end
        else if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            stall_cnt <= 0;
        end
        else if (stall_cnt >= STALL_LIMIT)
        begin
            $display("timeout: no traffic for %0d cycles", STALL_LIMIT);
            $display("reed_solomon_parity_gf256_top test failed");
            $finish;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    // overall cap on run length, in case traffic never stops
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_cycles <= 0;
        end
        else if (run_cycles >= RUN_LIMIT)
        begin
            $display("timeout: run exceeded %0d cycles", RUN_LIMIT);
            $display("reed_solomon_parity_gf256_top test failed");
            $finish;
        end
        else
        begin
            run_cycles <= run_cycles + 1;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic last);
        byte_backlog.push_back('{data: data, last: last});
    endtask

    task automatic queue_message(input int len);
        for (int k = 0; k < len; k++)
        begin
            push_byte(8'($urandom_range(255)), k == len - 1);
        end
    endtask

    task automatic queue_messages(input int n_items, input int short_max, input int long_max);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(1, long_max)
                                           : $urandom_range(1, short_max);
            queue_message(len);
            sent += len;
        end
    endtask

    // drain the backlog and all outstanding parity, then let the block go quiet
    task automatic settle();
        while (byte_backlog.size() != 0 || s_tvalid)
        begin
            @(posedge clk);
        end
        while (parity_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic apb_write(input logic [rsp_pkg::ADDR_W-1:0] addr,
                             input logic [rsp_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == DEGREE_ADDR)
        begin
            load_degree(value[rsp_pkg::CFG_W-1:0]);
            degree_writes++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [rsp_pkg::ADDR_W-1:0] addr,
                            output logic [rsp_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_degree(input logic [rsp_pkg::CFG_W-1:0] raw);
        settle();
        apb_write(DEGREE_ADDR, rsp_pkg::DATA_W'(raw));
        apb_read(DEGREE_ADDR, readback);
        if (readback !== rsp_pkg::DATA_W'(deg_raw))
        begin
            report_mismatch("ecc_degree readback", rsp_pkg::DATA_W'(deg_raw), readback);
        end
        @(posedge clk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct);
        settle();
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int sub = 0; sub < 2; sub++)
        begin
            set_degree(rsp_pkg::CFG_W'($urandom_range(0, 31)));
            queue_messages(22, 8, 30);
        end
    endtask

    initial
    begin
        load_degree(rsp_pkg::CFG_W'(rsp_pkg::RESET_DEGREE));
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset generator: all-zero, all-ones and a short mixed message
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b0);
        push_byte(8'h56, 1'b1);
        // leave a message open; the degree write below must discard it
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);

        // zero degree counts as one
        set_degree(rsp_pkg::CFG_W'(0));
        push_byte(8'hFF, 1'b1);
        push_byte(8'h80, 1'b0);
        push_byte(8'h01, 1'b1);

        // write to an unmapped address must leave the degree alone
        settle();
        apb_write(SPARE_ADDR, rsp_pkg::DATA_W'(5));
        apb_read(DEGREE_ADDR, readback);
        if (readback !== rsp_pkg::DATA_W'(deg_raw))
        begin
            report_mismatch("ecc_degree after unmapped write", rsp_pkg::DATA_W'(deg_raw),
                            readback);
        end
        @(posedge clk);
        push_byte(8'h7E, 1'b1);

        // all-ones register value clamps to the maximum degree
        set_degree(rsp_pkg::CFG_W'(31));
        push_byte(8'hFF, 1'b1);
        push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'($urandom_range(255)), 1'b0);
        push_byte(8'($urandom_range(255)), 1'b1);

        set_degree(rsp_pkg::CFG_W'(MAX_DEG));
        push_byte(8'h01, 1'b1);
        set_degree(rsp_pkg::CFG_W'(1));
        push_byte(8'hC3, 1'b0);
        push_byte(8'h3C, 1'b1);

        random_phase(0, 0);
        random_phase(60, 0);
        random_phase(0, 60);
        random_phase(35, 35);

        // short messages against a stalled receiver: fill the block and back up the input
        settle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_degree(rsp_pkg::CFG_W'(12));
        @(posedge clk);
        hold_req = 1'b1;
        queue_messages(45, 3, 3);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (parity_due.size() != 0)
        begin
            report_mismatch("parity words still outstanding", 32'h0, 32'(parity_due.size()));
        end
        $display("covered %0d message bytes in %0d messages, %0d parity words checked,",
                 bytes_in, msgs_in, words_out);
        $display("%0d degree writes incl. 0, 1, 20 and 31, idle/stall mixes, %0d-cycle hold-off",
                 degree_writes, HOLD_CYCLES);
        if (mismatch_cnt == 0)
        begin
            $display("reed_solomon_parity_gf256_top test passed");
        end
        else
        begin
            $display("%0d mismatches", mismatch_cnt);
            $display("reed_solomon_parity_gf256_top test failed");
        end
        $finish;
    end

endmodule
